### design/cbbf_pkg.sv
// shared constants, types and helpers of the content bounding box finder
package cbbf_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int MAX_DIM    = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;

    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;
    localparam int PIX_W     = 8;
    localparam int BOUND_W   = 10;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int SUM_W = $clog2(255 * MAX_DIM + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = CFG_IDX_W'(1);

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = CFG_W'(640);
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = CFG_W'(480);

    typedef struct packed {
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
    } pixel_t;

    typedef struct packed {
        logic [BOUND_W-1:0] top_row;
        logic [BOUND_W-1:0] bottom_row;
        logic [BOUND_W-1:0] left_column;
        logic [BOUND_W-1:0] right_column;
        logic               content_found;
    } bbox_t;

    typedef struct packed {
        logic [SUM_W-1:0] blue;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] red;
    } chan_sum_t;

    typedef struct packed {
        pixel_t           pix;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             first_row;
        logic             last_row;
        logic             row_end;
        logic             frame_end;
        logic [SUM_W-1:0] lim_w;
        logic [SUM_W-1:0] lim_h;
    } stage_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                   input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if ((CFG_W + DIM_W)'(v) > (CFG_W + DIM_W)'(maxv))
            r = maxv;
        else
            r = DIM_W'(v);
        return r;
    endfunction

    // 254 * n as (n << 8) - (n << 1)
    function automatic logic [SUM_W-1:0] white_limit(input logic [DIM_W-1:0] n);
        logic [SUM_W-1:0] a;
        logic [SUM_W-1:0] b;
        a = SUM_W'({n, 8'b0});
        b = SUM_W'({n, 1'b0});
        return a - b;
    endfunction

    function automatic logic is_white(input chan_sum_t s, input logic [SUM_W-1:0] lim);
        return (s.blue > lim) && (s.green > lim) && (s.red > lim);
    endfunction

endpackage

### design/cbbf_ram.sv
// generic single-port-write, registered-read ram
module cbbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/cbbf_scan.sv
// pixel intake: frame position counters, admission and the accumulate stage register
module cbbf_scan (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  cbbf_pkg::pixel_t              in_data,
    input  logic [cbbf_pkg::CFG_W-1:0]    frame_width,
    input  logic [cbbf_pkg::CFG_W-1:0]    frame_height,
    input  logic                          out_busy,
    output logic                          acc,
    output logic [cbbf_pkg::COL_W-1:0]    acc_col,
    output logic                          s1_valid,
    output cbbf_pkg::stage_t              s1
);

    import cbbf_pkg::*;

    logic [COL_W-1:0] col_pos_reg;
    logic [COL_W-1:0] col_pos_next;
    logic [ROW_W-1:0] row_pos_reg;
    logic [ROW_W-1:0] row_pos_next;
    logic             s1_valid_reg;
    stage_t           s1_reg;
    stage_t           s1_next;
    logic [DIM_W-1:0] w_eff;
    logic [DIM_W-1:0] h_eff;
    logic             last_row;
    logic             row_end;
    logic             frame_end;

    assign w_eff     = clamp_dim(frame_width, DIM_W'(MAX_WIDTH));
    assign h_eff     = clamp_dim(frame_height, DIM_W'(MAX_HEIGHT));
    assign last_row  = (DIM_W'(row_pos_reg) + DIM_W'(1)) >= h_eff;
    assign row_end   = (DIM_W'(col_pos_reg) + DIM_W'(1)) >= w_eff;
    assign frame_end = last_row && row_end;

    // a frame-end pixel needs a free result register when it leaves the stage
    assign in_ready = !(frame_end && out_busy);
    assign acc      = in_valid && in_ready;
    assign acc_col  = col_pos_reg;

    always_comb
    begin
        col_pos_next = col_pos_reg;
        row_pos_next = row_pos_reg;
        if (acc)
        begin
            if (row_end)
            begin
                col_pos_next = '0;
                row_pos_next = last_row ? '0 : row_pos_reg + ROW_W'(1);
            end
            else
            begin
                col_pos_next = col_pos_reg + COL_W'(1);
            end
        end
    end

    always_comb
    begin
        s1_next           = s1_reg;
        s1_next.pix       = in_data;
        s1_next.col       = col_pos_reg;
        s1_next.row       = row_pos_reg;
        s1_next.first_row = (row_pos_reg == '0);
        s1_next.last_row  = last_row;
        s1_next.row_end   = row_end;
        s1_next.frame_end = frame_end;
        s1_next.lim_w     = white_limit(w_eff);
        s1_next.lim_h     = white_limit(h_eff);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_pos_reg  <= '0;
            row_pos_reg  <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            col_pos_reg  <= col_pos_next;
            row_pos_reg  <= row_pos_next;
            s1_valid_reg <= acc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_reg <= s1_next;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1       = s1_reg;

endmodule

### design/cbbf_judge.sv
// accumulate stage: column sum update with forwarding, row sums, white tests, bounds, result
module cbbf_judge (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        acc,
    input  logic [cbbf_pkg::COL_W-1:0]  acc_col,
    input  logic                        s1_valid,
    input  cbbf_pkg::stage_t            s1,
    input  cbbf_pkg::chan_sum_t         col_rdata,
    output logic                        col_we,
    output logic [cbbf_pkg::COL_W-1:0]  col_waddr,
    output cbbf_pkg::chan_sum_t         col_wdata,
    output logic                        out_busy,
    output logic                        out_valid,
    input  logic                        out_ready,
    output cbbf_pkg::bbox_t             out_data
);

    import cbbf_pkg::*;

    logic             fwd_valid_reg;
    logic             fwd_valid_next;
    chan_sum_t        fwd_data_reg;
    chan_sum_t        col_base;
    chan_sum_t        col_new;
    chan_sum_t        row_tot_reg;
    chan_sum_t        row_tot_next;
    chan_sum_t        row_tot_new;
    logic             col_hit;
    logic             row_hit;
    logic [COL_W-1:0] left_reg;
    logic [COL_W-1:0] left_next;
    logic [COL_W-1:0] right_reg;
    logic [COL_W-1:0] right_next;
    logic [ROW_W-1:0] top_reg;
    logic [ROW_W-1:0] top_next;
    logic [ROW_W-1:0] bottom_reg;
    logic [ROW_W-1:0] bottom_next;
    logic             row_seen_reg;
    logic             row_seen_next;
    logic             col_seen_reg;
    logic             col_seen_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    bbox_t            out_data_reg;
    bbox_t            out_data_next;
    logic             finish;

    // same column read while the previous transfer writes it back
    assign fwd_valid_next = acc && s1_valid && (acc_col == s1.col);
    assign col_base       = fwd_valid_reg ? fwd_data_reg : col_rdata;

    always_comb
    begin
        if (s1.first_row)
        begin
            col_new.blue  = SUM_W'(s1.pix.blue);
            col_new.green = SUM_W'(s1.pix.green);
            col_new.red   = SUM_W'(s1.pix.red);
        end
        else
        begin
            col_new.blue  = col_base.blue + SUM_W'(s1.pix.blue);
            col_new.green = col_base.green + SUM_W'(s1.pix.green);
            col_new.red   = col_base.red + SUM_W'(s1.pix.red);
        end
        row_tot_new.blue  = row_tot_reg.blue + SUM_W'(s1.pix.blue);
        row_tot_new.green = row_tot_reg.green + SUM_W'(s1.pix.green);
        row_tot_new.red   = row_tot_reg.red + SUM_W'(s1.pix.red);
    end

    assign col_we    = s1_valid;
    assign col_waddr = s1.col;
    assign col_wdata = col_new;

    assign col_hit = s1_valid && s1.last_row && !is_white(col_new, s1.lim_h);
    assign row_hit = s1_valid && s1.row_end && !is_white(row_tot_new, s1.lim_w);
    assign finish  = s1_valid && s1.frame_end;

    always_comb
    begin
        left_next     = left_reg;
        right_next    = right_reg;
        top_next      = top_reg;
        bottom_next   = bottom_reg;
        row_seen_next = row_seen_reg;
        col_seen_next = col_seen_reg;
        row_tot_next  = row_tot_reg;
        out_data_next = out_data_reg;

        if (col_hit)
        begin
            if (!col_seen_reg)
            begin
                left_next = s1.col;
            end
            col_seen_next = 1'b1;
            right_next    = s1.col;
        end
        if (row_hit)
        begin
            if (!row_seen_reg)
            begin
                top_next = s1.row;
            end
            row_seen_next = 1'b1;
            bottom_next   = s1.row;
        end
        if (s1_valid)
        begin
            row_tot_next = s1.row_end ? '0 : row_tot_new;
        end

        if (finish)
        begin
            if (row_seen_next && col_seen_next)
            begin
                out_data_next.top_row       = BOUND_W'(top_next);
                out_data_next.bottom_row    = BOUND_W'(bottom_next);
                out_data_next.left_column   = BOUND_W'(left_next);
                out_data_next.right_column  = BOUND_W'(right_next);
                out_data_next.content_found = 1'b1;
            end
            else
            begin
                out_data_next = '0;
            end
            left_next     = '0;
            right_next    = '0;
            top_next      = '0;
            bottom_next   = '0;
            row_seen_next = 1'b0;
            col_seen_next = 1'b0;
        end
    end

    always_comb
    begin
        if (finish)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
            row_tot_reg   <= '0;
            left_reg      <= '0;
            right_reg     <= '0;
            top_reg       <= '0;
            bottom_reg    <= '0;
            row_seen_reg  <= 1'b0;
            col_seen_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fwd_valid_reg <= fwd_valid_next;
            row_tot_reg   <= row_tot_next;
            left_reg      <= left_next;
            right_reg     <= right_next;
            top_reg       <= top_next;
            bottom_reg    <= bottom_next;
            row_seen_reg  <= row_seen_next;
            col_seen_reg  <= col_seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= col_new;
        out_data_reg <= out_data_next;
    end

    assign out_busy  = out_valid_reg || finish;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### design/content_bounding_box_finder.sv
// top level of the content bounding box finder
//
// pixels stream in row-major order on in_valid/in_ready/in_data, one transfer
// per clock while in_ready is high. frame size comes from cfg_we, cfg_addr and
// cfg_data (index 0 width, index 1 height), to be written only while the block
// is idle (not enforced); out-of-range sizes clamp to 1 and to the maximum
// dimension. each pixel is taken at one per cycle: the column sum ram is read
// at the transfer and written back the next cycle, with a forward path when the
// same column comes back to back, so the read-modify-write loop sets the rate.
// after the last pixel of a frame passes the stage register, one result is
// registered on out_valid/out_data: inclusive first/last non-white row and
// column and a found flag. a waiting result does not block pixels; only the
// last pixel of the next frame is held off while the result register is still
// occupied. reset returns the size to 640x480 and clears positions, row sums
// and bounds; the column ram needs no clearing since the first row loads it.
module content_bounding_box_finder (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  cbbf_pkg::pixel_t               in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output cbbf_pkg::bbox_t                out_data,
    input  logic                           cfg_we,
    input  logic [cbbf_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [cbbf_pkg::CFG_W-1:0]     cfg_data
);

    import cbbf_pkg::*;

    logic [CFG_W-1:0] frame_width_reg;
    logic [CFG_W-1:0] frame_width_next;
    logic [CFG_W-1:0] frame_height_reg;
    logic [CFG_W-1:0] frame_height_next;
    logic             acc;
    logic [COL_W-1:0] acc_col;
    logic             s1_valid;
    stage_t           s1;
    chan_sum_t        col_rdata;
    logic             col_we;
    logic [COL_W-1:0] col_waddr;
    chan_sum_t        col_wdata;
    logic             out_busy;

    always_comb
    begin
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        if (cfg_we)
        begin
            case (cfg_addr)
                CFG_FRAME_WIDTH:  frame_width_next  = cfg_data;
                CFG_FRAME_HEIGHT: frame_height_next = cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
        end
        else
        begin
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
        end
    end

    cbbf_scan u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_data      (in_data),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .out_busy     (out_busy),
        .acc          (acc),
        .acc_col      (acc_col),
        .s1_valid     (s1_valid),
        .s1           (s1)
    );

    cbbf_ram #(
        .WIDTH ($bits(chan_sum_t)),
        .DEPTH (MAX_WIDTH)
    ) u_col_ram (
        .clk   (clk),
        .we    (col_we),
        .waddr (col_waddr),
        .wdata (col_wdata),
        .re    (acc),
        .raddr (acc_col),
        .rdata (col_rdata)
    );

    cbbf_judge u_judge (
        .clk       (clk),
        .rst_n     (rst_n),
        .acc       (acc),
        .acc_col   (acc_col),
        .s1_valid  (s1_valid),
        .s1        (s1),
        .col_rdata (col_rdata),
        .col_we    (col_we),
        .col_waddr (col_waddr),
        .col_wdata (col_wdata),
        .out_busy  (out_busy),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

### tb/sv/tb_content_bounding_box_finder.sv
// testbench of the content bounding box finder: streamed frames checked against an own bounds tracker
module tb_content_bounding_box_finder;

    timeunit 1ns;
    timeprecision 1ps;

    import cbbf_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 8;
    localparam int RANDOM_ITEMS   = 1700;

    localparam pixel_t WHITE_PX = '{blue: 8'hFF, green: 8'hFF, red: 8'hFF};

    typedef enum int {FILL_NOISE, FILL_BOX, FILL_BLANK, FILL_HAZE} fill_e;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    pixel_t               in_data;
    logic                 out_valid;
    logic                 out_ready;
    bbox_t                out_data;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_addr;
    logic [CFG_W-1:0]     cfg_data;

    // bounds tracker state
    logic [CFG_W-1:0] width_reg  = FRAME_WIDTH_RESET;
    logic [CFG_W-1:0] height_reg = FRAME_HEIGHT_RESET;
    int unsigned      row_blue, row_green, row_red;
    int unsigned      col_blue [MAX_WIDTH];
    int unsigned      col_green[MAX_WIDTH];
    int unsigned      col_red  [MAX_WIDTH];
    int unsigned      at_row, at_col;
    bit               row_hit, col_hit;
    int unsigned      bound_top, bound_bottom, bound_left, bound_right;
    bbox_t            expected_boxes[$];

    fill_e       fill_mode = FILL_NOISE;
    int unsigned box_top, box_bottom, box_left, box_right;
    bit          input_idle   = 1'b1;
    bit          ready_random = 1'b1;
    bit          hold_request = 1'b0;
    int          ready_gap    = 0;
    int          error_count  = 0;
    int          pixels_sent  = 0;

    content_bounding_box_finder u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int unsigned eff_size(input logic [CFG_W-1:0] v, input int unsigned limit);
        if (v == '0)
            return 1;
        if (v > limit)
            return limit;
        return v;
    endfunction

    function automatic bit over_white_limit(input int unsigned b, input int unsigned g,
                                            input int unsigned r, input int unsigned n);
        longint unsigned lim;
        lim = 64'd254 * n;
        return (b > lim) && (g > lim) && (r > lim);
    endfunction

    function automatic void clear_frame_state();
        row_blue = 0;
        row_green = 0;
        row_red = 0;
        at_row = 0;
        at_col = 0;
        row_hit = 1'b0;
        col_hit = 1'b0;
        bound_top = 0;
        bound_bottom = 0;
        bound_left = 0;
        bound_right = 0;
    endfunction

    function automatic void track_bounds(input pixel_t px);
        int unsigned w, h, c;
        bit          last_row, row_end;
        bbox_t       box;
        w = eff_size(width_reg, MAX_WIDTH);
        h = eff_size(height_reg, MAX_HEIGHT);
        c = at_col;
        last_row = (at_row + 1 >= h);
        row_end = (c + 1 >= w);
        if (c >= MAX_WIDTH)
            c = MAX_WIDTH - 1;
        row_blue += px.blue;
        row_green += px.green;
        row_red += px.red;
        if (at_row == 0)
        begin
            col_blue[c] = px.blue;
            col_green[c] = px.green;
            col_red[c] = px.red;
        end
        else
        begin
            col_blue[c] += px.blue;
            col_green[c] += px.green;
            col_red[c] += px.red;
        end
        if (last_row && !over_white_limit(col_blue[c], col_green[c], col_red[c], h))
        begin
            if (!col_hit)
            begin
                bound_left = c;
                col_hit = 1'b1;
            end
            bound_right = c;
        end
        if (!row_end)
        begin
            at_col = c + 1;
            return;
        end
        if (!over_white_limit(row_blue, row_green, row_red, w))
        begin
            if (!row_hit)
            begin
                bound_top = at_row;
                row_hit = 1'b1;
            end
            bound_bottom = at_row;
        end
        row_blue = 0;
        row_green = 0;
        row_red = 0;
        at_col = 0;
        if (!last_row)
        begin
            at_row++;
            return;
        end
        box = '0;
        if (row_hit && col_hit)
        begin
            box.top_row = bound_top[BOUND_W-1:0];
            box.bottom_row = bound_bottom[BOUND_W-1:0];
            box.left_column = bound_left[BOUND_W-1:0];
            box.right_column = bound_right[BOUND_W-1:0];
            box.content_found = 1'b1;
        end
        expected_boxes.push_back(box);
        clear_frame_state();
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic pixel_t random_px();
        pixel_t p;
        p.blue = $urandom_range(0, 255);
        p.green = $urandom_range(0, 255);
        p.red = $urandom_range(0, 255);
        return p;
    endfunction

    function automatic pixel_t haze_px(input int depth);
        pixel_t p;
        p.blue = 8'hFF - $urandom_range(0, depth);
        p.green = 8'hFF - $urandom_range(0, depth);
        p.red = 8'hFF - $urandom_range(0, depth);
        return p;
    endfunction

    function automatic pixel_t rgb(input int b, input int g, input int r);
        pixel_t p;
        p.blue = b;
        p.green = g;
        p.red = r;
        return p;
    endfunction

    function automatic pixel_t make_pixel();
        pixel_t p;
        bit     in_box;
        in_box = (at_row >= box_top) && (at_row <= box_bottom)
              && (at_col >= box_left) && (at_col <= box_right);
        p = WHITE_PX;
        case (fill_mode)
            FILL_NOISE: p = random_px();
            FILL_BOX:   if (in_box) p = $urandom_range(0, 1) ? random_px() : haze_px(2);
            FILL_HAZE:  p = haze_px(in_box ? 3 : 1);
            default:    p = WHITE_PX;
        endcase
        return p;
    endfunction

    function automatic void set_fill(input fill_e mode);
        int unsigned w, h;
        w = eff_size(width_reg, MAX_WIDTH);
        h = eff_size(height_reg, MAX_HEIGHT);
        fill_mode = mode;
        box_top = $urandom_range(0, h - 1);
        box_bottom = $urandom_range(box_top, h - 1);
        box_left = $urandom_range(0, w - 1);
        box_right = $urandom_range(box_left, w - 1);
    endfunction

    task automatic report_error(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic compare_field(input string name, input logic [BOUND_W-1:0] got,
                                 input logic [BOUND_W-1:0] want);
        if (got !== want)
            report_error($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // result checker
    always @(posedge clk)
    begin
        bbox_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_boxes.size() == 0)
                report_error("bounding box with none expected");
            else
            begin
                want = expected_boxes.pop_front();
                compare_field("top_row", out_data.top_row, want.top_row);
                compare_field("bottom_row", out_data.bottom_row, want.bottom_row);
                compare_field("left_column", out_data.left_column, want.left_column);
                compare_field("right_column", out_data.right_column, want.right_column);
                compare_field("content_found", BOUND_W'(out_data.content_found),
                              BOUND_W'(want.content_found));
            end
        end
    end

    // result receiver
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (ready_gap > 0)
            begin
                ready_gap--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (ready_random && $urandom_range(0, 3) == 0)
                    ready_gap = idle_len();
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    task automatic send_pixel(input pixel_t px);
        int gap;
        in_valid <= 1'b1;
        in_data <= px;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        track_bounds(px);
        pixels_sent++;
        gap = input_idle ? idle_len() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_pixels(input int n);
        repeat (n) send_pixel(make_pixel());
    endtask

    task automatic send_to_frame_end();
        do
            send_pixel(make_pixel());
        while (at_row != 0 || at_col != 0);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_boxes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_size(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_FRAME_WIDTH)
            width_reg = val;
        else
            height_reg = val;
        @(posedge clk);
    endtask

    task automatic write_frame_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        write_size(CFG_FRAME_WIDTH, w);
        write_size(CFG_FRAME_HEIGHT, h);
    endtask

    // one row at the reset size, then the height cut to two rows
    task automatic test_reset_size();
        set_fill(FILL_BOX);
        box_top = $urandom_range(0, 1);
        box_bottom = 1;
        send_pixels(640);
        wait_idle();
        write_size(CFG_FRAME_HEIGHT, 2);
        send_to_frame_end();
    endtask

    // rounding edge of the white test, rows without columns, tiny frames
    task automatic test_threshold_cases();
        pixel_t frame_a[12];
        pixel_t frame_b[4];
        frame_a = '{WHITE_PX, WHITE_PX, WHITE_PX, WHITE_PX,
                    WHITE_PX, WHITE_PX, rgb(254, 255, 255), WHITE_PX,
                    WHITE_PX, rgb(255, 255, 0), WHITE_PX, WHITE_PX};
        frame_b = '{rgb(254, 254, 254), rgb(254, 254, 254), WHITE_PX, WHITE_PX};
        wait_idle();
        write_frame_size(4, 3);
        foreach (frame_a[i])
            send_pixel(frame_a[i]);
        wait_idle();
        write_frame_size(2, 2);
        foreach (frame_b[i])
            send_pixel(frame_b[i]);
        wait_idle();
        write_frame_size(1, 1);
        send_pixel(WHITE_PX);
        send_pixel(rgb(0, 0, 0));
        send_pixel(rgb(255, 0, 255));
    endtask

    // sizes above the maximum and zero sizes
    task automatic test_size_extremes();
        wait_idle();
        write_frame_size(11'h7FF, 1);
        set_fill(FILL_BOX);
        send_to_frame_end();
        wait_idle();
        write_frame_size(1, 11'h7FF);
        set_fill(FILL_BOX);
        send_to_frame_end();
        wait_idle();
        write_frame_size(0, 0);
        send_pixel(rgb(0, 0, 0));
        send_pixel(WHITE_PX);
        wait_idle();
        write_frame_size(1025, 0);
        set_fill(FILL_HAZE);
        send_to_frame_end();
    endtask

    task automatic test_size_change_mid_frame();
        wait_idle();
        write_frame_size(6, 4);
        set_fill(FILL_NOISE);
        send_pixels(9);
        wait_idle();
        // column 3 lies past the new row end
        write_size(CFG_FRAME_WIDTH, 2);
        send_pixels(3);
        wait_idle();
        // row 3 lies past the new height, so it is the last
        write_size(CFG_FRAME_HEIGHT, 2);
        send_to_frame_end();
        wait_idle();
        write_frame_size(2, 3);
        set_fill(FILL_HAZE);
        send_pixels(3);
        wait_idle();
        write_size(CFG_FRAME_WIDTH, 5);
        send_to_frame_end();
    endtask

    task automatic test_output_backpressure();
        wait_idle();
        write_frame_size(2, 1);
        set_fill(FILL_NOISE);
        input_idle = 1'b0;
        hold_request = 1'b1;
        send_pixels(40);
        wait_idle();
        input_idle = 1'b1;
        write_frame_size(1, 1);
        send_pixels(30);
    endtask

    task automatic test_random_frames();
        int    stop_at, r;
        int    wv, hv;
        fill_e mode;
        stop_at = pixels_sent + RANDOM_ITEMS;
        while (pixels_sent < stop_at)
        begin
            if ($urandom_range(0, 2) != 0)
            begin
                r = $urandom_range(0, 19);
                if (r < 13)
                begin
                    wv = $urandom_range(1, 8);
                    hv = $urandom_range(1, 8);
                end
                else if (r < 16)
                begin
                    wv = $urandom_range(9, 48);
                    hv = $urandom_range(1, 4);
                end
                else if (r < 19)
                begin
                    wv = $urandom_range(1, 4);
                    hv = $urandom_range(9, 48);
                end
                else
                begin
                    wv = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
                    hv = (wv == 0) ? $urandom_range(0, 6) : 0;
                end
                wait_idle();
                write_frame_size(wv, hv);
            end
            r = $urandom_range(0, 9);
            mode = (r < 5) ? FILL_BOX : (r < 7) ? FILL_HAZE : (r < 9) ? FILL_NOISE : FILL_BLANK;
            set_fill(mode);
            input_idle = ($urandom_range(0, 3) != 0);
            ready_random = ($urandom_range(0, 3) != 0);
            send_to_frame_end();
        end
        ready_random = 1'b1;
    endtask

    initial
    begin
        in_valid <= 1'b0;
        in_data <= '0;
        cfg_we <= 1'b0;
        cfg_addr <= '0;
        cfg_data <= '0;
        rst_n <= 1'b0;
        clear_frame_state();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_size();
        test_threshold_cases();
        test_size_extremes();
        test_size_change_mid_frame();
        test_output_backpressure();
        test_random_frames();
        wait_idle();
        if (error_count == 0 && expected_boxes.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
